// ===== rtl/ksel_pkg.sv =====
// Shared types for the k-smallest selector.
// Holds the cell entry and the per-cycle control word broadcast along the cell chain.
// No dependencies.
package ksel_pkg;

	localparam int SCORE_W = 32;
	localparam int ID_W    = 16;
	localparam int KCFG_W  = 5;

	localparam logic [KCFG_W-1:0] K_RESET = KCFG_W'(16);

	typedef struct packed {
		logic                      occ;
		logic signed [SCORE_W-1:0] score;
		logic [ID_W-1:0]           id;
	} ksel_entry_t;

	typedef struct packed {
		logic        insert;
		logic        shift;
		ksel_entry_t item;
	} ksel_ctl_t;

endpackage

// ===== rtl/ksel_cell.sv =====
// One compare-and-shift cell of the sorted selection chain.
// Holds one (score, id) entry; takes the new item, its upper neighbor or its lower neighbor.
// Depends on ksel_pkg.
module ksel_cell import ksel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  ksel_ctl_t   ctl,
	input  ksel_entry_t prev,
	input  logic        prev_ins,
	input  ksel_entry_t next,
	output ksel_entry_t entry,
	output logic        ins
);

	logic                      occ_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [ID_W-1:0]           id_q;
	ksel_entry_t               nxt;

	assign entry = '{occ: occ_q & en, score: score_q, id: id_q};
	assign ins   = en & (~entry.occ | ($signed(ctl.item.score) < score_q));

	// hold the entry while disabled; drop it on the next input transfer
	always_comb begin
		nxt = '{occ: occ_q, score: score_q, id: id_q};
		if (!en) begin
			if (ctl.insert) begin
				nxt.occ = 1'b0;
			end
		end else if (ctl.insert && ins) begin
			nxt = prev_ins ? prev : ctl.item;
		end else if (ctl.shift) begin
			nxt = next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= nxt.occ;
		end
	end

	always_ff @(posedge clk) begin
		score_q <= nxt.score;
		id_q    <= nxt.id;
	end

endmodule

// ===== rtl/k_smallest_selector.sv =====
// Streaming k-smallest selector: a row of MAX_K sorted cells, one entry each.
// Throughput: one non-final item per cycle while in_stall is low; each is absorbed at
// its transfer edge. A final item is absorbed the same way; its list follows from the
// next cycle on, one result per cycle from the head cell while out_stall is low;
// n = min(max(k, 1), MAX_K, items since last list) results. Input stalls while a list
// is out. Reset empties all cells, sets k_q to 16; stored scores/ids are not cleared.
module k_smallest_selector import ksel_pkg::*; #(
	parameter int MAX_K = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [SCORE_W-1:0] score,
	input  logic [ID_W-1:0]           doc_id,
	input  logic                      final_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ID_W-1:0]           out_id,
	output logic signed [SCORE_W-1:0] out_score,
	output logic                      out_last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [KCFG_W-1:0]         k_in_use
);

	logic [KCFG_W-1:0] k_q;
	logic              emit_q;
	ksel_ctl_t         ctl;
	ksel_entry_t       cell_ent [MAX_K+1];
	logic              cell_ins [MAX_K];
	logic [MAX_K-1:0]  occ_vec;
	logic              in_xfer;
	logic              out_xfer;

	assign cfg_ready = 1'b1;
	assign in_stall  = emit_q;
	assign out_valid = emit_q;
	assign in_xfer   = in_valid & ~in_stall;
	assign out_xfer  = out_valid & ~out_stall;

	assign ctl = '{insert: in_xfer, shift: out_xfer,
		item: '{occ: 1'b1, score: score, id: doc_id}};

	assign cell_ent[MAX_K] = '0;

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		logic        en;
		ksel_entry_t prev;
		logic        prev_ins;

		assign en = (i == 0) || (32'(k_q) > i);
		if (i == 0) begin : g_head
			assign prev     = '0;
			assign prev_ins = 1'b0;
		end else begin : g_body
			assign prev     = cell_ent[i-1];
			assign prev_ins = cell_ins[i-1];
		end

		ksel_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl      (ctl),
			.prev     (prev),
			.prev_ins (prev_ins),
			.next     (cell_ent[i+1]),
			.entry    (cell_ent[i]),
			.ins      (cell_ins[i])
		);

		assign occ_vec[i] = cell_ent[i].occ;
	end

	assign out_id    = cell_ent[0].id;
	assign out_score = cell_ent[0].score;
	assign out_last  = ~cell_ent[1].occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= K_RESET;
			emit_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				k_q <= k_in_use;
			end
			if (in_xfer && final_item) begin
				emit_q <= 1'b1;
			end else if (out_xfer && out_last) begin
				emit_q <= 1'b0;
			end
		end
	end

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_ent[0].occ)
		else $error("list transfer from an empty head cell");

	a_occ_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec >> 1) & ~occ_vec) == '0)
		else $error("occupied cells not contiguous from the head");

	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && final_item |=> out_valid)
		else $error("final item did not start a list");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_last |=> !out_valid && occ_vec == '0)
		else $error("cells not empty after the last transfer");

endmodule
